@@ sv/cartridge_bank_irq_mapper_macros.svh @@
// Assertion macros shared by the cartridge bank and IRQ mapper modules.
`ifndef CARTRIDGE_BANK_IRQ_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_IRQ_MAPPER_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define CBIM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CBIM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/cbim_pkg.sv @@
// Types and constants of the cartridge bank and IRQ mapper.
package cbim_pkg;

	// item kinds
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_PRG   = 2'd2;
	localparam logic [1:0] REQ_CHR   = 2'd3;

	// board register selects
	localparam logic [3:0] REG_CHR_FIRST = 4'h0;
	localparam logic [3:0] REG_CHR_LAST  = 4'h7;
	localparam logic [3:0] REG_PRG       = 4'h8;
	localparam logic [3:0] REG_MIRROR    = 4'h9;
	localparam logic [3:0] REG_IRQ_EN    = 4'hA;
	localparam logic [3:0] REG_IRQ_ACK   = 4'hB;
	localparam logic [3:0] REG_RELOAD_LO = 4'hC;
	localparam logic [3:0] REG_RELOAD_HI = 4'hD;

	// configuration port
	localparam int CFG_DATA_W = 9;
	localparam logic [1:0] CFG_PRG_COUNT  = 2'd0;
	localparam logic [1:0] CFG_CHR_COUNT  = 2'd1;
	localparam logic [1:0] CFG_HDR_MIRROR = 2'd2;

	localparam logic [8:0] PRG_COUNT_RESET = 9'd2;
	localparam logic [4:0] CHR_COUNT_RESET = 5'd1;
	localparam logic [8:0] PRG_COUNT_MAX   = 9'd256;

	// remainder unit: one dividend bit per step
	localparam int MOD_STEPS = 8;
	localparam int MOD_CNT_W = 3;

	typedef struct packed {
		logic       start;
		logic [7:0] dividend;
		logic [8:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [7:0] remainder;
	} mod_rsp_t;

endpackage

@@ sv/cbim_mod_unit.sv @@
// Bit-serial restoring remainder unit: 8-bit dividend modulo a 9-bit divisor.
`include "cartridge_bank_irq_mapper_macros.svh"

module cbim_mod_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  cbim_pkg::mod_req_t req,
	output cbim_pkg::mod_rsp_t rsp
);

	logic                         busy_q;
	logic                         done_q;
	logic [cbim_pkg::MOD_CNT_W-1:0] cnt_q;
	logic [7:0]                   dvd_q;
	logic [7:0]                   rem_q;
	logic [8:0]                   div_q;

	logic [8:0] trial;
	logic [8:0] diff;
	logic       last;

	// shift in the next dividend bit, subtract when it fits
	assign trial = {rem_q, dvd_q[7]};
	assign diff  = trial - div_q;
	assign last  = cnt_q == cbim_pkg::MOD_CNT_W'(cbim_pkg::MOD_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[6:0], 1'b0};
			if (trial >= div_q) begin
				rem_q <= diff[7:0];
			end else begin
				rem_q <= trial[7:0];
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

	`CBIM_ASSERT(a_start_busy, clk, arst_n, req.start |=> busy_q, "start did not raise busy")
	`CBIM_ASSERT(a_last_done, clk, arst_n, (busy_q && last && !req.start) |=> (done_q && !busy_q),
		"last step did not finish")
	`CBIM_ASSERT(a_rem_range, clk, arst_n, done_q |-> ((div_q == 9'd0) || ({1'b0, rem_q} < div_q)),
		"remainder not below divisor")
	`CBIM_ASSERT_ALWAYS(a_done_idle, clk, !(done_q && busy_q), "done while still busy")

endmodule

@@ sv/cartridge_bank_irq_mapper.sv @@
// Cartridge bank and IRQ controller: board registers, IRQ counter, bank lookups.
// Each accepted item is one of four kinds: a board register write, a cycle
// tick of the 16-bit IRQ down-counter, a PRG window lookup or a CHR window
// lookup. One item is worked on at a time. Writes, ticks, PRG window 1 and
// lookups that map nothing skip the remainder unit; PRG window 0 and valid CHR
// lookups wait on the shared bit-serial remainder unit for the bank modulo. A
// finished result sits in the output register while the next item is accepted;
// the block waits at the end of an item only while that register is still full
// and out_ready is low. Configuration writes must come only while the block is
// idle; the block itself does not enforce it. Writing the header mirroring also
// loads the current mirroring mode.
`include "cartridge_bank_irq_mapper_macros.svh"

module cartridge_bank_irq_mapper #(
	parameter int CHR_WINDOWS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [cbim_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [3:0]                    reg_select,
	input  logic [7:0]                    write_data,
	input  logic [15:0]                   elapsed_cycles,
	input  logic [2:0]                    window_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    bank_number,
	output logic                          bank_valid,
	output logic [1:0]                    mirroring_mode,
	output logic                          irq_line
);

	localparam int CHR_IDX_W = $clog2(CHR_WINDOWS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration
	logic [8:0] prg_cnt_q;
	logic [4:0] chr_cnt_q;

	// board state
	logic [7:0]  chr_bank_q [CHR_WINDOWS];
	logic [3:0]  prg_bank_q;
	logic [1:0]  mirror_q;
	logic        irq_en_q;
	logic [15:0] irq_count_q;
	logic [15:0] irq_reload_q;
	logic        irq_pending_q;

	// accepted item
	logic [1:0]  kind_q;
	logic [3:0]  sel_q;
	logic [7:0]  data_q;
	logic [15:0] cycles_q;
	logic [2:0]  win_q;

	// staged and delivered result
	logic [7:0] res_bank_q;
	logic       res_valid_q;
	logic       out_valid_q;
	logic [7:0] out_bank_q;
	logic       out_bvalid_q;
	logic [1:0] out_mirror_q;
	logic       out_irq_q;

	cbim_pkg::mod_req_t mod_req;
	cbim_pkg::mod_rsp_t mod_rsp;

	logic       in_fire;
	logic       out_load;
	logic [8:0] prg_eff;
	logic [7:0] chr_total;
	logic [7:0] chr_sel_bank;
	logic       prg_ok;
	logic       chr_ok;
	logic       need_mod;

	assign in_ready = state_q == S_IDLE;
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	assign prg_eff      = (prg_cnt_q > cbim_pkg::PRG_COUNT_MAX) ? cbim_pkg::PRG_COUNT_MAX
	                                                           : prg_cnt_q;
	assign chr_total    = {chr_cnt_q, 3'b000};
	assign chr_sel_bank = chr_bank_q[win_q[CHR_IDX_W-1:0]];
	assign prg_ok       = (prg_eff != 9'd0) && (win_q < 3'd2);
	assign chr_ok       = chr_total != 8'd0;
	assign need_mod     = ((kind_q == cbim_pkg::REQ_PRG) && prg_ok && (win_q == 3'd0)) ||
	                      ((kind_q == cbim_pkg::REQ_CHR) && chr_ok);

	assign mod_req.start    = (state_q == S_EXEC) && need_mod;
	assign mod_req.dividend = (kind_q == cbim_pkg::REQ_PRG) ? {4'd0, prg_bank_q} : chr_sel_bank;
	assign mod_req.divisor  = (kind_q == cbim_pkg::REQ_PRG) ? prg_eff : {1'b0, chr_total};

	cbim_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= need_mod ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (mod_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// latch the item
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q   <= req_type;
			sel_q    <= reg_select;
			data_q   <= write_data;
			cycles_q <= elapsed_cycles;
			win_q    <= window_index;
		end
	end

	// configuration and board registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_cnt_q     <= cbim_pkg::PRG_COUNT_RESET;
			chr_cnt_q     <= cbim_pkg::CHR_COUNT_RESET;
			for (int i = 0; i < CHR_WINDOWS; i++) begin
				chr_bank_q[i] <= 8'(i);
			end
			prg_bank_q    <= '0;
			mirror_q      <= '0;
			irq_en_q      <= 1'b0;
			irq_count_q   <= '0;
			irq_reload_q  <= '0;
			irq_pending_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cbim_pkg::CFG_PRG_COUNT: prg_cnt_q <= cfg_wdata;
					cbim_pkg::CFG_CHR_COUNT: chr_cnt_q <= cfg_wdata[4:0];
					cbim_pkg::CFG_HDR_MIRROR: begin
						mirror_q <= {1'b0, cfg_wdata[0]};
					end
					default: ;
				endcase
			end
			if (state_q == S_EXEC) begin
				if (kind_q == cbim_pkg::REQ_WRITE) begin
					case (sel_q) inside
						[cbim_pkg::REG_CHR_FIRST:cbim_pkg::REG_CHR_LAST]:
							chr_bank_q[sel_q[CHR_IDX_W-1:0]] <= data_q;
						cbim_pkg::REG_PRG:    prg_bank_q <= data_q[3:0];
						cbim_pkg::REG_MIRROR: mirror_q   <= data_q[1:0];
						cbim_pkg::REG_IRQ_EN: begin
							irq_en_q      <= data_q[0];
							irq_pending_q <= 1'b0;
						end
						cbim_pkg::REG_IRQ_ACK: begin
							irq_pending_q <= 1'b0;
							irq_count_q   <= irq_reload_q;
						end
						cbim_pkg::REG_RELOAD_LO: irq_reload_q[7:0]  <= data_q;
						cbim_pkg::REG_RELOAD_HI: irq_reload_q[15:8] <= data_q;
						default: ;
					endcase
				end else if ((kind_q == cbim_pkg::REQ_TICK) && irq_en_q) begin
					irq_count_q <= irq_count_q - cycles_q;
					// raise on borrow out of the counter
					if (cycles_q > irq_count_q) begin
						irq_pending_q <= 1'b1;
					end
				end
			end
		end
	end

	// stage the bank result
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			res_bank_q  <= '0;
			res_valid_q <= 1'b0;
			if (kind_q == cbim_pkg::REQ_PRG) begin
				res_valid_q <= prg_ok;
				if (prg_ok && (win_q == 3'd1)) begin
					res_bank_q <= 8'(prg_eff - 9'd1);
				end
			end else if (kind_q == cbim_pkg::REQ_CHR) begin
				res_valid_q <= chr_ok;
			end
		end else if ((state_q == S_DIV) && mod_rsp.done) begin
			res_bank_q <= mod_rsp.remainder;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_bank_q   <= res_bank_q;
			out_bvalid_q <= res_valid_q;
			out_mirror_q <= mirror_q;
			out_irq_q    <= irq_pending_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign bank_number    = out_bank_q;
	assign bank_valid     = out_bvalid_q;
	assign mirroring_mode = out_mirror_q;
	assign irq_line       = out_irq_q;

	`CBIM_ASSERT(a_accept_exec, clk, arst_n, in_fire |=> (state_q == S_EXEC), "accept without exec")
	`CBIM_ASSERT(a_div_busy, clk, arst_n, ((state_q == S_DIV) && !mod_rsp.done) |-> mod_rsp.busy,
		"waiting on an idle remainder unit")
	`CBIM_ASSERT(a_done_in_div, clk, arst_n, mod_rsp.done |-> (state_q == S_DIV),
		"remainder finished outside the wait state")
	`CBIM_ASSERT(a_irq_by_tick, clk, arst_n,
		$rose(irq_pending_q) |-> $past((state_q == S_EXEC) && (kind_q == cbim_pkg::REQ_TICK)),
		"interrupt raised without a tick")

endmodule

@@ tb/tb_cartridge_bank_irq_mapper.sv @@
// Testbench of the cartridge bank and IRQ mapper: directed and random items.
`timescale 1ns / 1ps

module tb_cartridge_bank_irq_mapper;

	localparam logic [3:0] REG_SPARE_E = 4'hE;
	localparam logic [3:0] REG_SPARE_F = 4'hF;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PRINT_LIMIT = 30;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  sel;
		logic [7:0]  data;
		logic [15:0] cycles;
		logic [2:0]  win;
	} bus_item_t;

	typedef struct packed {
		logic [7:0] bank;
		logic       valid;
		logic [1:0] mirror;
		logic       irq;
	} bank_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [cbim_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [1:0] req_type;
	logic [3:0] reg_select;
	logic [7:0] write_data;
	logic [15:0] elapsed_cycles;
	logic [2:0] window_index;
	logic out_valid;
	logic out_ready;
	logic [7:0] bank_number;
	logic bank_valid;
	logic [1:0] mirroring_mode;
	logic irq_line;

	// predictor state
	logic [8:0]  prg_count;
	logic [4:0]  chr_banks_8k;
	logic [7:0]  chr_bank [8];
	logic [3:0]  prg_bank;
	logic [1:0]  mirror_mode;
	logic        irq_en;
	logic [15:0] irq_cnt;
	logic [15:0] irq_reload;
	logic        irq_pend;

	bank_result_t expected_q [$];
	bank_result_t want;
	bus_item_t seen_item;

	bit idle_on;
	int err_count;
	int sent_items;
	int result_count;
	int mapped_count;
	int irq_high_count;
	int cfg_count;
	int idle_cycles;

	cartridge_bank_irq_mapper u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.reg_select(reg_select),
		.write_data(write_data),
		.elapsed_cycles(elapsed_cycles),
		.window_index(window_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bank_number(bank_number),
		.bank_valid(bank_valid),
		.mirroring_mode(mirroring_mode),
		.irq_line(irq_line)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic void reset_board();
		prg_count = cbim_pkg::PRG_COUNT_RESET;
		chr_banks_8k = cbim_pkg::CHR_COUNT_RESET;
		for (int i = 0; i < 8; i++) chr_bank[i] = 8'(i);
		prg_bank = '0;
		mirror_mode = '0;
		irq_en = 1'b0;
		irq_cnt = '0;
		irq_reload = '0;
		irq_pend = 1'b0;
	endfunction

	// Update the board state for one item and return the result it produces.
	function automatic bank_result_t map_item(input bus_item_t it);
		bank_result_t r;
		logic [8:0] prg_span;
		logic [7:0] chr_span;
		r = '0;
		case (it.kind)
			cbim_pkg::REQ_WRITE: begin
				if (it.sel <= cbim_pkg::REG_CHR_LAST) begin
					chr_bank[it.sel[2:0]] = it.data;
				end else begin
					case (it.sel)
						cbim_pkg::REG_PRG: prg_bank = it.data[3:0];
						cbim_pkg::REG_MIRROR: mirror_mode = it.data[1:0];
						cbim_pkg::REG_IRQ_EN: begin
							irq_en = it.data[0];
							irq_pend = 1'b0;
						end
						cbim_pkg::REG_IRQ_ACK: begin
							irq_pend = 1'b0;
							irq_cnt = irq_reload;
						end
						cbim_pkg::REG_RELOAD_LO: irq_reload[7:0] = it.data;
						cbim_pkg::REG_RELOAD_HI: irq_reload[15:8] = it.data;
						default: ;
					endcase
				end
			end
			cbim_pkg::REQ_TICK: begin
				if (irq_en) begin
					if (it.cycles > irq_cnt) irq_pend = 1'b1;
					irq_cnt = irq_cnt - it.cycles;
				end
			end
			cbim_pkg::REQ_PRG: begin
				prg_span = (prg_count > cbim_pkg::PRG_COUNT_MAX) ? cbim_pkg::PRG_COUNT_MAX
				                                                 : prg_count;
				if (prg_span != 0 && it.win < 2) begin
					r.valid = 1'b1;
					r.bank = (it.win == 0) ? 8'(prg_bank % prg_span) : 8'(prg_span - 1);
				end
			end
			default: begin
				chr_span = {chr_banks_8k, 3'b000};
				if (chr_span != 0) begin
					r.valid = 1'b1;
					r.bank = chr_bank[it.win] % chr_span;
				end
			end
		endcase
		r.mirror = mirror_mode;
		r.irq = irq_pend;
		return r;
	endfunction

	function automatic bus_item_t make_item(logic [1:0] kind, logic [3:0] sel, logic [7:0] data,
			logic [15:0] cycles, logic [2:0] win);
		bus_item_t it;
		it = {kind, sel, data, cycles, win};
		return it;
	endfunction

	function automatic bus_item_t rand_item();
		bus_item_t it;
		it.kind = 2'($urandom_range(0, 3));
		it.sel = 4'($urandom_range(0, 15));
		it.data = 8'($urandom);
		it.cycles = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 300)) : 16'($urandom);
		it.win = 3'($urandom_range(0, 7));
		if (it.kind == cbim_pkg::REQ_PRG && $urandom_range(0, 3) != 0)
			it.win = 3'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		err_count++;
		if (err_count <= PRINT_LIMIT)
			$display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
				$time, result_count, what, got, exp_val);
	endtask

	task automatic send_item(input bus_item_t it);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		{req_type, reg_select, write_data, elapsed_cycles, window_index} = it;
		in_valid = 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		sent_items++;
	endtask

	// Hold the sender until every expected result is back and the block has settled.
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx,
			input logic [cbim_pkg::CFG_DATA_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		case (idx)
			cbim_pkg::CFG_PRG_COUNT: prg_count = value;
			cbim_pkg::CFG_CHR_COUNT: chr_banks_8k = value[4:0];
			cbim_pkg::CFG_HDR_MIRROR: mirror_mode = {1'b0, value[0]};
			default: ;
		endcase
		cfg_count++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_rom(input logic [8:0] prg, input logic [4:0] chr, input logic hdr);
		write_cfg(cbim_pkg::CFG_PRG_COUNT, prg);
		write_cfg(cbim_pkg::CFG_CHR_COUNT, {4'd0, chr});
		write_cfg(cbim_pkg::CFG_HDR_MIRROR, {8'd0, hdr});
	endtask

	task automatic test_reset_state();
		send_item(make_item(cbim_pkg::REQ_PRG, 4'h0, 8'h00, 16'h0000, 3'd0));
		send_item(make_item(cbim_pkg::REQ_PRG, 4'h0, 8'h00, 16'h0000, 3'd1));
		send_item(make_item(cbim_pkg::REQ_PRG, 4'h0, 8'h00, 16'h0000, 3'd7));
		send_item(make_item(cbim_pkg::REQ_CHR, 4'h0, 8'h00, 16'h0000, 3'd0));
		send_item(make_item(cbim_pkg::REQ_CHR, 4'h0, 8'h00, 16'h0000, 3'd7));
		// counter is disabled: nothing moves
		send_item(make_item(cbim_pkg::REQ_TICK, 4'h0, 8'h00, 16'hFFFF, 3'd0));
	endtask

	task automatic test_board_registers();
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_CHR_FIRST, 8'hFF, 16'h0000,
			3'd0));
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_CHR_LAST, 8'h00, 16'h0000,
			3'd0));
		send_item(make_item(cbim_pkg::REQ_CHR, 4'h0, 8'h00, 16'h0000, 3'd0));
		send_item(make_item(cbim_pkg::REQ_CHR, 4'h0, 8'h00, 16'h0000, 3'd7));
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_PRG, 8'hFF, 16'h0000, 3'd0));
		send_item(make_item(cbim_pkg::REQ_PRG, 4'h0, 8'h00, 16'h0000, 3'd0));
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_MIRROR, 8'hFF, 16'h0000, 3'd0));
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_MIRROR, 8'h02, 16'h0000, 3'd0));
		send_item(make_item(cbim_pkg::REQ_WRITE, REG_SPARE_E, 8'hFF, 16'hFFFF, 3'd7));
		send_item(make_item(cbim_pkg::REQ_WRITE, REG_SPARE_F, 8'hFF, 16'hFFFF, 3'd7));
	endtask

	task automatic test_irq_counter();
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_RELOAD_LO, 8'hFF, 16'h0000,
			3'd0));
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_RELOAD_HI, 8'hFF, 16'h0000,
			3'd0));
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_IRQ_ACK, 8'h00, 16'h0000,
			3'd0));
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_IRQ_EN, 8'h01, 16'h0000, 3'd0));
		// zero-length tick never underflows, then count down exactly to zero
		send_item(make_item(cbim_pkg::REQ_TICK, 4'h0, 8'h00, 16'h0000, 3'd0));
		send_item(make_item(cbim_pkg::REQ_TICK, 4'h0, 8'h00, 16'hFFFF, 3'd0));
		send_item(make_item(cbim_pkg::REQ_TICK, 4'h0, 8'h00, 16'h0001, 3'd0));
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_IRQ_ACK, 8'h00, 16'h0000,
			3'd0));
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_IRQ_EN, 8'h00, 16'h0000, 3'd0));
		send_item(make_item(cbim_pkg::REQ_TICK, 4'h0, 8'h00, 16'h0005, 3'd0));
	endtask

	// Sweep the ROM sizes, including no ROM at all and a PRG count past the top.
	task automatic test_rom_sizes();
		logic [8:0] prg_set [6] = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd257, 9'd3};
		logic [4:0] chr_set [6] = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd0, 5'd5};
		bus_item_t it;
		for (int s = 0; s < 6; s++) begin
			set_rom(prg_set[s], chr_set[s], 1'(s % 2 == 0));
			repeat (12) begin
				it = rand_item();
				if (it.kind == cbim_pkg::REQ_TICK) it.kind = cbim_pkg::REQ_CHR;
				send_item(it);
			end
		end
	endtask

	// Arm the counter and run it down through a short burst of ticks and random items.
	task automatic run_irq_sequence();
		bus_item_t it;
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_RELOAD_LO, 8'($urandom),
			16'($urandom), 3'($urandom)));
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_RELOAD_HI,
			($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)),
			16'($urandom), 3'($urandom)));
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_IRQ_ACK, 8'($urandom),
			16'($urandom), 3'($urandom)));
		send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_IRQ_EN, 8'($urandom) | 8'h01,
			16'($urandom), 3'($urandom)));
		repeat ($urandom_range(3, 8)) begin
			it = rand_item();
			if ($urandom_range(0, 2) != 0) begin
				it.kind = cbim_pkg::REQ_TICK;
				it.cycles = 16'($urandom_range(0, 200));
			end
			send_item(it);
		end
		if ($urandom_range(0, 1) == 0)
			send_item(make_item(cbim_pkg::REQ_WRITE, cbim_pkg::REG_IRQ_ACK, 8'($urandom),
				16'($urandom), 3'($urandom)));
	endtask

	task automatic test_random_traffic(input int count, input bit with_idle);
		int target;
		target = sent_items + count;
		idle_on = with_idle;
		while (sent_items < target) begin
			if ($urandom_range(0, 9) < 6) run_irq_sequence();
			else send_item(rand_item());
			if ($urandom_range(0, 39) == 0) wait_drained();
		end
	endtask

	// Drive out_ready in stall bursts while idling is on.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Predict on every accepted item, check every accepted result, watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing expected", bank_number, 0);
				end else begin
					want = expected_q.pop_front();
					if (bank_number !== want.bank)
						report_mismatch("bank_number", bank_number, want.bank);
					if (bank_valid !== want.valid)
						report_mismatch("bank_valid", bank_valid, want.valid);
					if (mirroring_mode !== want.mirror)
						report_mismatch("mirroring_mode", mirroring_mode, want.mirror);
					if (irq_line !== want.irq)
						report_mismatch("irq_line", irq_line, want.irq);
					if (want.valid) mapped_count++;
					if (want.irq) irq_high_count++;
				end
				result_count++;
			end
			if (in_valid && in_ready) begin
				seen_item = {req_type, reg_select, write_data, elapsed_cycles, window_index};
				expected_q.push_back(map_item(seen_item));
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
					$display("tb_cartridge_bank_irq_mapper: done, errors");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		{req_type, reg_select, write_data, elapsed_cycles, window_index} = '0;
		idle_on = 1'b1;
		err_count = 0;
		sent_items = 0;
		result_count = 0;
		mapped_count = 0;
		irq_high_count = 0;
		cfg_count = 0;
		idle_cycles = 0;
		reset_board();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_board_registers();
		test_irq_counter();
		test_rom_sizes();
		for (int p = 0; p < 4; p++) begin
			if ($urandom_range(0, 3) == 0) set_rom(9'($urandom), 5'($urandom), 1'($urandom));
			else set_rom(9'($urandom_range(1, 256)), 5'($urandom), 1'($urandom));
			// no idling in the last part
			test_random_traffic(88, p != 3);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("covered %0d items and %0d config writes; %0d results, %0d mapped banks,",
			sent_items, cfg_count, result_count, mapped_count);
		$display("%0d results with the interrupt raised, %0d mismatches", irq_high_count,
			err_count);
		if (err_count == 0 && expected_q.size() == 0) begin
			$display("tb_cartridge_bank_irq_mapper: done, clean");
		end else begin
			if (expected_q.size() != 0)
				$display("%0d expected results never arrived", expected_q.size());
			$display("tb_cartridge_bank_irq_mapper: done, errors");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/cbim_pkg.sv
sv/cbim_mod_unit.sv
sv/cartridge_bank_irq_mapper.sv
tb/tb_cartridge_bank_irq_mapper.sv
